/* hdl/sfd_pkg.sv */
// Shared types and byte codes for the stuffed frame deframer and checker.
`timescale 1ns / 1ps

package sfd_pkg;

  // Framing byte codes
  localparam logic [7:0] BYTE_SOF = 8'h80;
  localparam logic [7:0] BYTE_EOF = 8'h81;
  localparam logic [7:0] BYTE_ESC = 8'h82;

  // Escaped bytes get this offset added
  localparam logic [7:0] ESC_OFFSET = 8'h80;

  // Message identifiers that select a reply action
  localparam logic [7:0] MSG_REPLY05 = 8'h05;
  localparam logic [7:0] MSG_EVENT   = 8'h07;
  localparam logic [7:0] MSG_REPLY04 = 8'h04;
  localparam logic [7:0] MSG_ID83    = 8'h83;
  localparam logic [7:0] MSG_ID03    = 8'h03;

  // Event sub types of the event message
  localparam logic [7:0] SUB_MESSAGE = 8'h00;
  localparam logic [7:0] SUB_ALERT   = 8'h01;
  localparam logic [7:0] SUB_LOWBATT = 8'h02;

  // Checksum adjustments
  localparam logic [23:0] ADJ_REPLY05 = 24'h000081;
  localparam logic [23:0] ADJ_80      = 24'h000080;

  // Field widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned SUM_W = 24;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_DROP   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISMATCH = 2'd1,
    STAT_SHORT    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_REPLY05  = 3'd1,
    ACT_MESSAGE  = 3'd2,
    ACT_ALERT    = 3'd3,
    ACT_LOWBATT  = 3'd4,
    ACT_REPLY04  = 3'd5,
    ACT_ID83TO03 = 3'd6,
    ACT_ID03TO83 = 3'd7
  } action_e;

  // One result transfer
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic [IDX_W-1:0]  byte_index;
    status_e           frame_status;
    logic [7:0]        message_id;
    action_e           action;
    logic [SUM_W-1:0]  reply_checksum;
  } res_t;

  // Result of one decode step
  typedef struct packed {
    logic valid;
    res_t res;
  } step_t;

endpackage

/* hdl/sfd_in_buf.sv */
// Input register with skid stage for the received byte stream.
`timescale 1ns / 1ps

module sfd_in_buf (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       pop_i,
  output logic       st_valid_o,
  output logic [7:0] st_byte_o
);

  logic       st_valid_q, st_valid_d;
  logic [7:0] st_byte_q, st_byte_d;
  logic       sk_valid_q, sk_valid_d;
  logic [7:0] sk_byte_q, sk_byte_d;
  logic       accept;
  logic       st_free;

  assign in_stall_o = sk_valid_q;
  assign accept     = in_valid_i & ~sk_valid_q;
  assign st_free    = ~st_valid_q | pop_i;

  // Refill the stage from the skid first, then from the port
  always_comb begin
    st_valid_d = st_valid_q;
    st_byte_d  = st_byte_q;
    sk_valid_d = sk_valid_q;
    sk_byte_d  = sk_byte_q;
    if (st_free) begin
      if (sk_valid_q) begin
        st_valid_d = 1'b1;
        st_byte_d  = sk_byte_q;
        sk_valid_d = 1'b0;
      end else begin
        st_valid_d = accept;
        st_byte_d  = rx_byte_i;
      end
    end else if (accept) begin
      sk_valid_d = 1'b1;
      sk_byte_d  = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      sk_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
      sk_valid_q <= sk_valid_d;
    end
  end

  // Hold payload, no reset needed
  always_ff @(posedge clk_i) begin
    st_byte_q <= st_byte_d;
    sk_byte_q <= sk_byte_d;
  end

  assign st_valid_o = st_valid_q;
  assign st_byte_o  = st_byte_q;

endmodule

/* hdl/sfd_core.sv */
// Frame state and single-step decode, checksum and end-of-frame report.
`timescale 1ns / 1ps

module sfd_core import sfd_pkg::*; #(
  parameter int unsigned MAX_FRAME = 640,
  parameter int unsigned RAW_LIMIT = 1408
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output step_t      step_o
);

  localparam int unsigned DCW = $clog2(MAX_FRAME + 1);
  localparam int unsigned RCW = $clog2(RAW_LIMIT + 1);
  localparam int unsigned CMPW = LEN_W + 1;

  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic [DCW-1:0]    dcnt_q, dcnt_d;
  logic [RCW-1:0]    rcnt_q, rcnt_d;
  logic [LEN_W-1:0]  flen_q, flen_d;
  logic [SUM_W-1:0]  rsum_q, rsum_d;
  logic [7:0]        msg_q, msg_d;
  logic [7:0]        sub_q, sub_d;
  logic [SUM_W-1:0]  rxsum_q, rxsum_d;

  logic [7:0]        val;
  logic [LEN_W-1:0]  len;
  logic [CMPW-1:0]   idx_w;
  logic [CMPW-1:0]   sum_lim;
  logic [CMPW-1:0]   end_lim;
  logic [CMPW-1:0]   frm_lim;
  logic [LEN_W-1:0]  idx_ext;
  logic              is_short;
  status_e           status;
  action_e           act;
  logic [SUM_W-1:0]  rep_sum;
  step_t             step;

  // Decoded byte and the length that applies to it
  assign val      = esc_q ? (byte_i + ESC_OFFSET) : byte_i;
  assign len      = (dcnt_q >= DCW'(2)) ? flen_q : {LEN_W{1'b1}};
  assign idx_w    = CMPW'(dcnt_q);
  assign sum_lim  = {1'b0, len} + CMPW'(4);
  assign end_lim  = {1'b0, len} + CMPW'(7);
  assign frm_lim  = {1'b0, flen_q} + CMPW'(7);
  assign idx_ext  = LEN_W'(dcnt_q);
  assign is_short = (dcnt_q < DCW'(2)) || (idx_w < frm_lim);

  // Work out status, action and adjusted checksum for the report
  always_comb begin
    act     = ACT_NONE;
    rep_sum = rsum_q;
    if (is_short) begin
      status = STAT_SHORT;
    end else if (rxsum_q != rsum_q) begin
      status = STAT_MISMATCH;
    end else begin
      status = STAT_OK;
      case (msg_q)
        MSG_REPLY05: begin
          act     = ACT_REPLY05;
          rep_sum = rsum_q + ADJ_REPLY05;
        end
        MSG_EVENT: begin
          if (sub_q == SUB_MESSAGE)      act = ACT_MESSAGE;
          else if (sub_q == SUB_ALERT)   act = ACT_ALERT;
          else if (sub_q == SUB_LOWBATT) act = ACT_LOWBATT;
        end
        MSG_REPLY04: begin
          act     = ACT_REPLY04;
          rep_sum = rsum_q + ADJ_80;
        end
        MSG_ID83: begin
          act     = ACT_ID83TO03;
          rep_sum = rsum_q - ADJ_80;
        end
        MSG_ID03: begin
          act     = ACT_ID03TO83;
          rep_sum = rsum_q + ADJ_80;
        end
        default: ;
      endcase
    end
  end

  // Advance the frame state for one transfer
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    dcnt_d     = dcnt_q;
    rcnt_d     = rcnt_q;
    flen_d     = flen_q;
    rsum_d     = rsum_q;
    msg_d      = msg_q;
    sub_d      = sub_q;
    rxsum_d    = rxsum_q;
    step       = '0;
    if (fire_i) begin
      if (byte_i == BYTE_SOF) begin
        // Open a frame, restarting any open one
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        dcnt_d     = '0;
        rcnt_d     = RCW'(1);
        flen_d     = {LEN_W{1'b1}};
        rsum_d     = '0;
        msg_d      = '0;
        sub_d      = '0;
        rxsum_d    = '0;
      end else if (in_frame_q) begin
        if (byte_i == BYTE_EOF) begin
          in_frame_d              = 1'b0;
          esc_d                   = 1'b0;
          step.valid              = 1'b1;
          step.res.kind           = KIND_REPORT;
          step.res.frame_status   = status;
          step.res.message_id     = msg_q;
          step.res.action         = act;
          step.res.reply_checksum = rep_sum;
        end else if (rcnt_q >= RCW'(RAW_LIMIT)) begin
          // Drop on raw overflow
          in_frame_d    = 1'b0;
          esc_d         = 1'b0;
          step.valid    = 1'b1;
          step.res.kind = KIND_DROP;
        end else begin
          rcnt_d = rcnt_q + RCW'(1);
          if (byte_i == BYTE_ESC) begin
            esc_d = 1'b1;
          end else if (dcnt_q >= DCW'(MAX_FRAME)) begin
            // Drop on decoded overflow
            in_frame_d    = 1'b0;
            esc_d         = 1'b0;
            step.valid    = 1'b1;
            step.res.kind = KIND_DROP;
          end else begin
            esc_d = 1'b0;
            if (dcnt_q == DCW'(0)) flen_d = {8'h00, val};
            if (dcnt_q == DCW'(1)) flen_d = {flen_q[7:0], val};
            if (dcnt_q == DCW'(4)) msg_d = val;
            if (dcnt_q == DCW'(5)) sub_d = val;
            if (idx_w < sum_lim) begin
              rsum_d = rsum_q + SUM_W'(val);
            end else if (idx_w < end_lim) begin
              rxsum_d = {rxsum_q[SUM_W-9:0], val};
            end
            dcnt_d              = dcnt_q + DCW'(1);
            step.valid          = 1'b1;
            step.res.kind       = KIND_DATA;
            step.res.data_byte  = val;
            step.res.byte_index = idx_ext[IDX_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      dcnt_q     <= '0;
      rcnt_q     <= '0;
      flen_q     <= {LEN_W{1'b1}};
      rsum_q     <= '0;
      msg_q      <= '0;
      sub_q      <= '0;
      rxsum_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      dcnt_q     <= dcnt_d;
      rcnt_q     <= rcnt_d;
      flen_q     <= flen_d;
      rsum_q     <= rsum_d;
      msg_q      <= msg_d;
      sub_q      <= sub_d;
      rxsum_q    <= rxsum_d;
    end
  end

  assign step_o = step;

endmodule

/* hdl/stuffed_frame_deframer_checker.sv */
// Top level of the stuffed frame deframer with additive checksum check.
`timescale 1ns / 1ps

// Takes one received byte per transfer and undoes the byte stuffing (0x80 opens
// a frame, 0x81 closes it, 0x82 escapes the next byte). Each decoded byte comes
// out with its index; a close gives a report with status, message id, action
// and adjusted reply checksum; an overflow gives a drop transfer. Framing and
// escape bytes give no result. One byte is taken every cycle while no stall
// holds the flow: the decode step is a single pass from the input stage
// register to the result register, and a byte passes the input stage register
// first. A skid stage on the input keeps in_stall_o a registered signal.

module stuffed_frame_deframer_checker import sfd_pkg::*; #(
  parameter int unsigned MAX_FRAME = 640,
  parameter int unsigned RAW_LIMIT = 1408
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  byte_index_o,
  output logic [1:0]  frame_status_o,
  output logic [7:0]  message_id_o,
  output logic [2:0]  action_o,
  output logic [23:0] reply_checksum_o
);

  logic       st_valid;
  logic [7:0] st_byte;
  logic       out_free;
  logic       pop;
  step_t      step;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop      = st_valid & out_free;

  sfd_in_buf u_in_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .pop_i      (pop),
    .st_valid_o (st_valid),
    .st_byte_o  (st_byte)
  );

  sfd_core #(
    .MAX_FRAME (MAX_FRAME),
    .RAW_LIMIT (RAW_LIMIT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (pop),
    .byte_i (st_byte),
    .step_o (step)
  );

  // Load a new result, or hold one still stalled
  assign out_valid_d = (pop & step.valid) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && step.valid) begin
      out_q <= step.res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign byte_index_o     = out_q.byte_index;
  assign frame_status_o   = out_q.frame_status;
  assign message_id_o     = out_q.message_id;
  assign action_o         = out_q.action;
  assign reply_checksum_o = out_q.reply_checksum;

endmodule

/* tb/tb_stuffed_frame_deframer_checker.sv */
// Self-checking testbench for the stuffed frame deframer and additive checksum checker.
`timescale 1ns / 1ps

module tb_stuffed_frame_deframer_checker;
  import sfd_pkg::*;

  localparam int unsigned MAX_FRAME      = 640;
  localparam int unsigned RAW_LIMIT      = 1408;
  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned IDLE_PERCENT   = 21;
  localparam int unsigned HOLDOFF_AT     = 200;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned QUIET_FROM     = 1200;
  localparam int unsigned QUIET_TO       = 1700;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum int {
    END_CLOSE,
    END_TRUNCATE,
    END_ABANDON,
    END_ESC_CLOSE
  } frame_end_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [9:0]  byte_index_o;
  logic [1:0]  frame_status_o;
  logic [7:0]  message_id_o;
  logic [2:0]  action_o;
  logic [23:0] reply_checksum_o;

  // Raw byte stream waiting to be sent, and decoded results still owed
  logic [7:0]  rx_stream[$];
  res_t        expected_results[$];

  bit          in_busy;
  int unsigned bytes_accepted;
  int unsigned frame_items;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned holdoff_left;
  bit          holdoff_done;

  // Deframer state as predicted from the accepted bytes, starting from reset
  logic        fr_open = 1'b0;
  logic        fr_esc = 1'b0;
  logic [9:0]  fr_dec = '0;
  logic [10:0] fr_raw = '0;
  logic [15:0] fr_len = 16'hFFFF;
  logic [23:0] fr_sum = '0;
  logic [23:0] fr_rx_sum = '0;
  logic [7:0]  fr_id = '0;
  logic [7:0]  fr_sub = '0;

  stuffed_frame_deframer_checker #(
    .MAX_FRAME (MAX_FRAME),
    .RAW_LIMIT (RAW_LIMIT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .frame_status_o   (frame_status_o),
    .message_id_o     (message_id_o),
    .action_o         (action_o),
    .reply_checksum_o (reply_checksum_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_framing(input logic [7:0] b);
    return b == BYTE_SOF || b == BYTE_EOF || b == BYTE_ESC;
  endfunction

  function automatic bit quiet_window();
    return bytes_accepted >= QUIET_FROM && bytes_accepted < QUIET_TO;
  endfunction

  // Advance the predicted deframer by one raw byte and queue what it emits
  function automatic void deframe_byte(input logic [7:0] b);
    res_t        r;
    logic [7:0]  v;
    int unsigned idx;
    int unsigned len;
    r = '0;
    if (b == BYTE_SOF) begin
      fr_open   = 1'b1;
      fr_esc    = 1'b0;
      fr_dec    = '0;
      fr_raw    = 11'd1;
      fr_len    = 16'hFFFF;
      fr_sum    = '0;
      fr_rx_sum = '0;
      fr_id     = '0;
      fr_sub    = '0;
      return;
    end
    if (!fr_open) return;
    // Close: report status, id, action and adjusted checksum
    if (b == BYTE_EOF) begin
      r.kind           = KIND_REPORT;
      r.message_id     = fr_id;
      r.action         = ACT_NONE;
      r.reply_checksum = fr_sum;
      if (fr_dec < 2 || fr_dec < fr_len + 7) begin
        r.frame_status = STAT_SHORT;
      end else if (fr_rx_sum != fr_sum) begin
        r.frame_status = STAT_MISMATCH;
      end else begin
        r.frame_status = STAT_OK;
        case (fr_id)
          MSG_REPLY05: begin
            r.action         = ACT_REPLY05;
            r.reply_checksum = fr_sum + ADJ_REPLY05;
          end
          MSG_EVENT: begin
            if (fr_sub == SUB_MESSAGE) r.action = ACT_MESSAGE;
            else if (fr_sub == SUB_ALERT) r.action = ACT_ALERT;
            else if (fr_sub == SUB_LOWBATT) r.action = ACT_LOWBATT;
          end
          MSG_REPLY04: begin
            r.action         = ACT_REPLY04;
            r.reply_checksum = fr_sum + ADJ_80;
          end
          MSG_ID83: begin
            r.action         = ACT_ID83TO03;
            r.reply_checksum = fr_sum - ADJ_80;
          end
          MSG_ID03: begin
            r.action         = ACT_ID03TO83;
            r.reply_checksum = fr_sum + ADJ_80;
          end
          default: ;
        endcase
      end
      fr_open = 1'b0;
      fr_esc  = 1'b0;
      expected_results.push_back(r);
      return;
    end
    // Drop on too many raw bytes
    if (fr_raw >= RAW_LIMIT) begin
      r.kind  = KIND_DROP;
      fr_open = 1'b0;
      fr_esc  = 1'b0;
      expected_results.push_back(r);
      return;
    end
    fr_raw = fr_raw + 1'b1;
    if (b == BYTE_ESC) begin
      fr_esc = 1'b1;
      return;
    end
    // Drop on too many decoded bytes
    if (fr_dec >= MAX_FRAME) begin
      r.kind  = KIND_DROP;
      fr_open = 1'b0;
      fr_esc  = 1'b0;
      expected_results.push_back(r);
      return;
    end
    v      = fr_esc ? b + ESC_OFFSET : b;
    fr_esc = 1'b0;
    idx    = fr_dec;
    len    = (idx >= 2) ? fr_len : 16'hFFFF;
    if (idx == 0) fr_len = {8'h00, v};
    else if (idx == 1) fr_len = {fr_len[7:0], v};
    if (idx == 4) fr_id = v;
    if (idx == 5) fr_sub = v;
    if (idx < len + 4) fr_sum = fr_sum + v;
    else if (idx < len + 7) fr_rx_sum = {fr_rx_sum[15:0], v};
    fr_dec = fr_dec + 1'b1;
    r.kind       = KIND_DATA;
    r.data_byte  = v;
    r.byte_index = idx[9:0];
    expected_results.push_back(r);
  endfunction

  // Stuff one decoded byte: framing values must be escaped, others sometimes are
  task automatic push_decoded(input logic [7:0] v);
    if (is_framing(v) || (!is_framing(v - ESC_OFFSET) && $urandom_range(7) == 0)) begin
      rx_stream.push_back(BYTE_ESC);
      rx_stream.push_back(v - ESC_OFFSET);
    end else begin
      rx_stream.push_back(v);
    end
  endtask

  // Build one frame: length, body with id and sub type, checksum, optional tail
  task automatic send_frame(input logic [15:0] len, input logic [7:0] id,
                            input logic [7:0] sub, input bit bad_sum,
                            input int unsigned extra, input frame_end_e how);
    logic [7:0]  body[$];
    logic [23:0] sum;
    int unsigned start;
    int unsigned n;
    int unsigned cut;
    start = rx_stream.size();
    sum   = '0;
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    // Huge lengths can never be satisfied, so send only a short body
    n = (len > 60) ? $urandom_range(3, 20) : len + 4;
    while (body.size() < n) body.push_back(8'($urandom_range(255)));
    if (n > 4) body[4] = id;
    if (n > 5) body[5] = sub;
    if (len <= 60) begin
      foreach (body[i]) sum = sum + body[i];
      if (bad_sum) sum = sum ^ (24'h1 << $urandom_range(23));
      body.push_back(sum[23:16]);
      body.push_back(sum[15:8]);
      body.push_back(sum[7:0]);
    end
    repeat (extra) body.push_back(8'($urandom_range(255)));
    cut = (how == END_TRUNCATE) ? $urandom_range(body.size() - 1) : body.size();
    rx_stream.push_back(BYTE_SOF);
    for (int i = 0; i < cut; i++) push_decoded(body[i]);
    case (how)
      END_ESC_CLOSE: begin
        rx_stream.push_back(BYTE_ESC);
        rx_stream.push_back(BYTE_EOF);
      end
      END_ABANDON: ;
      default: rx_stream.push_back(BYTE_EOF);
    endcase
    frame_items += rx_stream.size() - start;
  endtask

  // Stimulus, reset and end of run
  initial begin
    logic [7:0]  b;
    logic [7:0]  id;
    logic [7:0]  sub;
    logic [15:0] len;
    int unsigned pick;
    int unsigned raw_n;
    bit          long_done;
    frame_end_e  how;

    // Bytes outside a frame are ignored
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(BYTE_EOF);
    rx_stream.push_back(BYTE_ESC);
    // Empty frame closes short
    rx_stream.push_back(BYTE_SOF);
    rx_stream.push_back(BYTE_EOF);
    // Pending escape is forgotten at a restart and at a close
    rx_stream.push_back(BYTE_SOF);
    rx_stream.push_back(BYTE_ESC);
    rx_stream.push_back(BYTE_SOF);
    rx_stream.push_back(BYTE_ESC);
    rx_stream.push_back(BYTE_EOF);
    // Smallest frames: one carries an id with the subtracting action, one a bad checksum
    send_frame(16'd1, MSG_ID83, SUB_MESSAGE, 1'b0, 0, END_CLOSE);
    send_frame(16'd0, MSG_REPLY05, SUB_MESSAGE, 1'b1, 0, END_CLOSE);

    frame_items = 0;
    long_done   = 1'b0;
    while (frame_items < RANDOM_ITEMS) begin
      // Halfway through, overflow the decoded count and then the raw count
      if (!long_done && frame_items >= RANDOM_ITEMS / 2) begin
        long_done = 1'b1;
        rx_stream.push_back(BYTE_SOF);
        repeat (MAX_FRAME + 1) push_decoded(8'($urandom_range(255)));
        rx_stream.push_back(BYTE_SOF);
        raw_n = 0;
        while (raw_n < RAW_LIMIT - 1) begin
          if (raw_n < RAW_LIMIT - 2 && $urandom_range(9) == 0) begin
            do b = 8'($urandom_range(255)); while (is_framing(b));
            rx_stream.push_back(BYTE_ESC);
            rx_stream.push_back(b);
            raw_n += 2;
          end else begin
            rx_stream.push_back(BYTE_ESC);
            raw_n++;
          end
        end
        b = 8'($urandom_range(255));
        if (b == BYTE_SOF) b = BYTE_EOF;
        rx_stream.push_back(b);
      end

      pick = $urandom_range(99);
      if (pick < 80) len = 16'($urandom_range(8));
      else if (pick < 95) len = 16'($urandom_range(9, 40));
      else len = 16'($urandom_range(61, 65535));
      case ($urandom_range(6))
        0: id = MSG_REPLY05;
        1: id = MSG_EVENT;
        2: id = MSG_REPLY04;
        3: id = MSG_ID83;
        4: id = MSG_ID03;
        default: id = 8'($urandom_range(255));
      endcase
      sub  = ($urandom_range(3) != 0) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 82) how = END_CLOSE;
      else if (pick < 90) how = END_TRUNCATE;
      else if (pick < 95) how = END_ABANDON;
      else how = END_ESC_CLOSE;
      send_frame(len, id, sub, $urandom_range(4) == 0,
                 ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0, how);

      // Line noise between frames
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(255));
          if (b != BYTE_SOF) rx_stream.push_back(b);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_stream.size() != 0 || in_busy || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("stuffed_frame_deframer_checker regression: pass");
    end else begin
      $display("stuffed_frame_deframer_checker regression: fail");
    end
    $finish;
  end

  // Byte driver: offer the next byte or idle; hold the offered byte until taken
  always @(negedge clk_i) begin
    if (rst_ni && !in_busy) begin
      if (rx_stream.size() != 0 && (quiet_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
        rx_byte_i  <= rx_stream.pop_front();
        in_valid_i <= 1'b1;
        in_busy     = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall: one long hold-off, a quiet stretch, random stalls otherwise
  always @(negedge clk_i) begin
    if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AT) begin
      out_stall_i <= 1'b1;
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
    end else if (quiet_window()) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Monitor: check each result transfer, then predict from each byte transfer
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (out_valid_o && !out_stall_i) begin
      got.kind           = kind_e'(kind_o);
      got.data_byte      = data_byte_o;
      got.byte_index     = byte_index_o;
      got.frame_status   = status_e'(frame_status_o);
      got.message_id     = message_id_o;
      got.action         = action_e'(action_o);
      got.reply_checksum = reply_checksum_o;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind=%0d byte=%02h idx=%0d", $time,
                   kind_o, data_byte_o, byte_index_o);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.byte_index !== want.byte_index || got.frame_status !== want.frame_status ||
            got.message_id !== want.message_id || got.action !== want.action ||
            got.reply_checksum !== want.reply_checksum) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch exp kind=%0d byte=%02h idx=%0d st=%0d id=%02h act=%0d",
                     $time, want.kind, want.data_byte, want.byte_index,
                     want.frame_status, want.message_id, want.action);
            $display("    exp sum=%06h got kind=%0d byte=%02h idx=%0d st=%0d id=%02h",
                     want.reply_checksum, got.kind, got.data_byte, got.byte_index,
                     got.frame_status, got.message_id);
            $display("    got act=%0d sum=%06h", got.action, got.reply_checksum);
          end
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      deframe_byte(rx_byte_i);
      bytes_accepted++;
      in_busy = 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stuffed_frame_deframer_checker regression: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
hdl/sfd_pkg.sv
hdl/sfd_in_buf.sv
hdl/sfd_core.sv
hdl/stuffed_frame_deframer_checker.sv
tb/tb_stuffed_frame_deframer_checker.sv
